// File: rtl/core/qte_pkg.sv
// ----------------------------------------------------------------------------
// qte_pkg: shared constants and types for the quaternion to Euler converter
// Widths, CORDIC arctangent table and the operand bundle that moves from the
// front end through the square-root delay line.
// ----------------------------------------------------------------------------
`default_nettype none
package qte_pkg;

	localparam int CORDIC_STAGES   = 16;   // 8..24 rotation stages
	localparam int COMPONENT_WIDTH = 16;   // 12..32, bits of a field that count

	localparam int FIELD_W  = 16;
	localparam int EFF_W    = (COMPONENT_WIDTH < FIELD_W) ? COMPONENT_WIDTH : FIELD_W;
	localparam int EXT_SH   = FIELD_W - EFF_W;
	localparam int PROD_W   = 2 * FIELD_W;           // one product of two components
	localparam int OP_W     = PROD_W + 2;            // atan2 operands and cross terms
	localparam int NORM_W   = PROD_W + 1;            // squared norm
	localparam int ROOT_W   = PROD_W;                // square root result
	localparam int RAD_W    = 2 * ROOT_W;            // radicand
	localparam int REM_W    = ROOT_W + 3;            // square root partial remainder
	localparam int SQ_STEP  = 2;                     // root bits resolved per stage
	localparam int SQ_STAGES = ROOT_W / SQ_STEP;
	localparam int POS_W    = $clog2(OP_W);
	localparam int NORM_MSB = 30;                    // operands normalized to [2^30, 2^31)
	localparam int CW       = NORM_MSB + 5;          // CORDIC x and y
	localparam int ZW       = 32;                    // CORDIC angle, 2^-28 rad
	localparam int MAG_W    = 30;                    // angle magnitude
	localparam int DEG_W    = 28;
	localparam int DPROD_W  = MAG_W + DEG_W;
	localparam int ANG_W    = 15;
	localparam int FRONT_LAT = 4;
	localparam int ATAN_LAT = CORDIC_STAGES + 6;

	localparam logic [MAG_W-1:0] HALF_PI_Q28 = MAG_W'(421657428);
	localparam logic [MAG_W-1:0] PI_Q28      = MAG_W'(843314857);
	localparam logic [DEG_W-1:0] DEG_MULT    = DEG_W'(240315917);
	localparam int DEG_SH = 44;
	localparam int RAD_SH = 16;
	localparam int ANG_MAX = 12868;

	// atan(2^-s) in units of 2^-28 rad
	localparam logic [MAG_W-1:0] ATAN_TAB [24] = '{
		30'd210828714, 30'd124459457, 30'd65760959, 30'd33381290, 30'd16755422,
		30'd8385879, 30'd4193963, 30'd2097109, 30'd1048571, 30'd524287,
		30'd262144, 30'd131072, 30'd65536, 30'd32768, 30'd16384, 30'd8192,
		30'd4096, 30'd2048, 30'd1024, 30'd512, 30'd256, 30'd128, 30'd64, 30'd32
	};

	typedef struct packed {
		logic signed [OP_W-1:0] yaw_y;
		logic signed [OP_W-1:0] yaw_x;
		logic signed [OP_W-1:0] roll_y;
		logic signed [OP_W-1:0] roll_x;
		logic [ROOT_W-1:0]      pit_a;
		logic                   pit_neg;
		logic                   zero;
	} opnd_t;

	typedef struct packed {
		logic xneg;
		logic yneg;
		logic zero;
	} quad_t;

	// keep the low EFF_W bits of a field, sign-extended
	function automatic logic signed [FIELD_W-1:0] sext_comp(input logic [FIELD_W-1:0] v);
		logic [FIELD_W-1:0] sh;
		sh = v << EXT_SH;
		sext_comp = $signed(sh) >>> EXT_SH;
	endfunction

endpackage
`default_nettype wire

// File: rtl/core/qte_front.sv
// ----------------------------------------------------------------------------
// qte_front: products, cross terms and pitch radicand
// Four stages: ten products, sums, arcsine clamp, radicand multiply.
// ----------------------------------------------------------------------------
`default_nettype none
module qte_front (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_valid,
	input  logic [qte_pkg::FIELD_W-1:0]       quat_real,
	input  logic [qte_pkg::FIELD_W-1:0]       quat_i,
	input  logic [qte_pkg::FIELD_W-1:0]       quat_j,
	input  logic [qte_pkg::FIELD_W-1:0]       quat_k,
	output logic                              out_valid,
	output qte_pkg::opnd_t                    out_op,
	output logic [qte_pkg::RAD_W-1:0]         out_rad
);
	localparam int OP_W   = qte_pkg::OP_W;
	localparam int PROD_W = qte_pkg::PROD_W;
	localparam int NORM_W = qte_pkg::NORM_W;
	localparam int ROOT_W = qte_pkg::ROOT_W;
	localparam int RAD_W  = qte_pkg::RAD_W;

	function automatic logic signed [OP_W-1:0] ext(input logic signed [PROD_W-1:0] p);
		ext = OP_W'(p);
	endfunction

	logic signed [qte_pkg::FIELD_W-1:0] cr, ci, cj, ck;
	logic signed [PROD_W-1:0] p_rr_s1, p_ii_s1, p_jj_s1, p_kk_s1, p_ij_s1, p_kr_s1;
	logic signed [PROD_W-1:0] p_jk_s1, p_ir_s1, p_ik_s1, p_jr_s1;
	logic v_s1, v_s2, v_s3, v_s4;
	logic signed [OP_W-1:0] yaw_y_s2, yaw_x_s2, roll_y_s2, roll_x_s2, t_s2;
	logic [NORM_W-1:0] n_s2;
	logic signed [OP_W-1:0] nsum;
	logic [OP_W-1:0] tmag;
	logic [NORM_W-1:0] amag, acl, nh, ah, npa;
	logic [ROOT_W-1:0] nma_s3;
	logic [NORM_W-1:0] npa_s3;
	qte_pkg::opnd_t op_s3, op_s4;
	logic [RAD_W-1:0] rad_s4;

	assign cr = qte_pkg::sext_comp(quat_real);
	assign ci = qte_pkg::sext_comp(quat_i);
	assign cj = qte_pkg::sext_comp(quat_j);
	assign ck = qte_pkg::sext_comp(quat_k);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// stage 1: products
	always_ff @(posedge clk) begin
		if (en) begin
			p_rr_s1 <= cr * cr;
			p_ii_s1 <= ci * ci;
			p_jj_s1 <= cj * cj;
			p_kk_s1 <= ck * ck;
			p_ij_s1 <= ci * cj;
			p_kr_s1 <= ck * cr;
			p_jk_s1 <= cj * ck;
			p_ir_s1 <= ci * cr;
			p_ik_s1 <= ci * ck;
			p_jr_s1 <= cj * cr;
		end
	end

	// stage 2: cross terms and squared norm
	assign nsum = ext(p_ii_s1) + ext(p_jj_s1) + ext(p_kk_s1) + ext(p_rr_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			yaw_y_s2  <= (ext(p_ij_s1) + ext(p_kr_s1)) <<< 1;
			yaw_x_s2  <= ext(p_ii_s1) - ext(p_jj_s1) - ext(p_kk_s1) + ext(p_rr_s1);
			roll_y_s2 <= (ext(p_jk_s1) + ext(p_ir_s1)) <<< 1;
			roll_x_s2 <= ext(p_kk_s1) + ext(p_rr_s1) - ext(p_ii_s1) - ext(p_jj_s1);
			t_s2      <= (ext(p_jr_s1) - ext(p_ik_s1)) <<< 1;
			n_s2      <= nsum[NORM_W-1:0];
		end
	end

	// stage 3: saturate the arcsine term to the norm, halve at the top of range
	always_comb begin
		tmag = t_s2[OP_W-1] ? OP_W'(-t_s2) : OP_W'(t_s2);
		amag = tmag[NORM_W-1:0];
		acl  = (amag > n_s2) ? n_s2 : amag;
		nh   = n_s2[NORM_W-1] ? (n_s2 >> 1) : n_s2;
		ah   = n_s2[NORM_W-1] ? (acl >> 1) : acl;
		npa  = nh + ah;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			nma_s3         <= ROOT_W'(nh - ah);
			npa_s3         <= npa;
			op_s3.yaw_y    <= yaw_y_s2;
			op_s3.yaw_x    <= yaw_x_s2;
			op_s3.roll_y   <= roll_y_s2;
			op_s3.roll_x   <= roll_x_s2;
			op_s3.pit_a    <= ah[ROOT_W-1:0];
			op_s3.pit_neg  <= t_s2[OP_W-1];
			op_s3.zero     <= (n_s2 == '0);
		end
	end

	// stage 4: radicand (n - a)(n + a)
	always_ff @(posedge clk) begin
		if (en) begin
			rad_s4 <= RAD_W'({1'b0, nma_s3} * npa_s3);
			op_s4  <= op_s3;
		end
	end

	assign out_valid = v_s4;
	assign out_op    = op_s4;
	assign out_rad   = rad_s4;
endmodule
`default_nettype wire

// File: rtl/core/qte_isqrt.sv
// ----------------------------------------------------------------------------
// qte_isqrt: pipelined integer square root
// Restoring digit recurrence, two root bits per stage, floor result.
// ----------------------------------------------------------------------------
`default_nettype none
module qte_isqrt (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         in_valid,
	input  logic [qte_pkg::RAD_W-1:0]    rad,
	output logic                         out_valid,
	output logic [qte_pkg::ROOT_W-1:0]   root
);
	localparam int N      = qte_pkg::SQ_STAGES;
	localparam int RAD_W  = qte_pkg::RAD_W;
	localparam int ROOT_W = qte_pkg::ROOT_W;
	localparam int REM_W  = qte_pkg::REM_W;

	logic [RAD_W-1:0]  rad_s  [N+1];
	logic [REM_W-1:0]  rem_s  [N+1];
	logic [ROOT_W-1:0] root_s [N+1];
	logic [N:0]        v_s;

	assign rad_s[0]  = rad;
	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign v_s[0]    = in_valid;

	for (genvar g = 0; g < N; g++) begin : g_stage
		logic [RAD_W-1:0]  rv;
		logic [REM_W-1:0]  rem, cand, trial;
		logic [ROOT_W-1:0] rt;

		always_comb begin
			rv  = rad_s[g];
			rem = rem_s[g];
			rt  = root_s[g];
			for (int st = 0; st < qte_pkg::SQ_STEP; st++) begin
				cand  = {rem[REM_W-3:0], rv[RAD_W-1 -: 2]};
				trial = {1'b0, rt, 2'b01};
				if (cand >= trial) begin
					rem = cand - trial;
					rt  = {rt[ROOT_W-2:0], 1'b1};
				end else begin
					rem = cand;
					rt  = {rt[ROOT_W-2:0], 1'b0};
				end
				rv = rv << 2;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[g+1] <= 1'b0;
			end else if (en) begin
				v_s[g+1] <= v_s[g];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rad_s[g+1]  <= rv;
				rem_s[g+1]  <= rem;
				root_s[g+1] <= rt;
			end
		end
	end

	assign out_valid = v_s[N];
	assign root      = root_s[N];
endmodule
`default_nettype wire

// File: rtl/core/qte_atan2.sv
// ----------------------------------------------------------------------------
// qte_atan2: pipelined four-quadrant arctangent with output scaling
// Magnitudes, leading-one search, normalize, CORDIC vectoring chain,
// quadrant fix, unit conversion with round half up.
// ----------------------------------------------------------------------------
`default_nettype none
module qte_atan2 (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                en,
	input  logic                                in_valid,
	input  logic signed [qte_pkg::OP_W-1:0]     y_in,
	input  logic signed [qte_pkg::OP_W-1:0]     x_in,
	input  logic                                deg,
	output logic                                out_valid,
	output logic [qte_pkg::ANG_W-1:0]           angle
);
	localparam int OP_W  = qte_pkg::OP_W;
	localparam int POS_W = qte_pkg::POS_W;
	localparam int CW    = qte_pkg::CW;
	localparam int ZW    = qte_pkg::ZW;
	localparam int MAG_W = qte_pkg::MAG_W;
	localparam int N     = qte_pkg::CORDIC_STAGES;
	localparam int NM    = qte_pkg::NORM_MSB;
	localparam int ANG_W = qte_pkg::ANG_W;
	localparam int DPW   = qte_pkg::DPROD_W;

	logic [OP_W-1:0] ax, ay;
	logic [OP_W-1:0] ax_s1, ay_s1, m_s1, ax_s2, ay_s2;
	qte_pkg::quad_t  q_s1, q_s2;
	logic [POS_W-1:0] pos, pos_s2, sh;
	logic [OP_W-1:0] xs, ys;
	logic v_s1, v_s2, v_s4, v_s5, v_s6;

	logic signed [CW-1:0] cx_s [N+1];
	logic signed [CW-1:0] cy_s [N+1];
	logic signed [ZW-1:0] cz_s [N+1];
	qte_pkg::quad_t       cq_s [N+1];
	logic [N:0]           cv_s;

	logic signed [ZW-1:0] zc;
	logic [MAG_W-1:0] mag, mag_s4, mag_s5;
	logic neg_s4, neg_s5;
	logic [DPW-1:0] prod_s5;
	logic [DPW:0]   dsum;
	logic [MAG_W:0] rsum;
	logic [ANG_W-1:0] r, angle_s6;

	// stage 1: magnitudes
	always_comb begin
		ax = x_in[OP_W-1] ? OP_W'(-x_in) : OP_W'(x_in);
		ay = y_in[OP_W-1] ? OP_W'(-y_in) : OP_W'(y_in);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			cv_s[0] <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			cv_s[0] <= v_s2;
			v_s4 <= cv_s[N];
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_s1     <= ax;
			ay_s1     <= ay;
			m_s1      <= (ax > ay) ? ax : ay;
			q_s1.xneg <= x_in[OP_W-1];
			q_s1.yneg <= y_in[OP_W-1];
			q_s1.zero <= (ax == '0) && (ay == '0);
		end
	end

	// stage 2: leading one of the larger magnitude
	always_comb begin
		pos = '0;
		for (int b = 0; b < OP_W; b++) begin
			if (m_s1[b]) pos = POS_W'(b);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pos_s2 <= pos;
			ax_s2  <= ax_s1;
			ay_s2  <= ay_s1;
			q_s2   <= q_s1;
		end
	end

	// stage 3: move the leading one to bit NM
	always_comb begin
		if (pos_s2 > POS_W'(NM)) begin
			sh = pos_s2 - POS_W'(NM);
			xs = ax_s2 >> sh;
			ys = ay_s2 >> sh;
		end else begin
			sh = POS_W'(NM) - pos_s2;
			xs = ax_s2 << sh;
			ys = ay_s2 << sh;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cx_s[0] <= $signed(CW'(xs[NM:0]));
			cy_s[0] <= $signed(CW'(ys[NM:0]));
			cz_s[0] <= '0;
			cq_s[0] <= q_s2;
		end
	end

	// rotation chain, one micro-rotation per stage
	for (genvar s = 0; s < N; s++) begin : g_rot
		logic signed [CW-1:0] dx, dy;
		logic signed [ZW-1:0] ts;

		assign dx = cy_s[s] >>> s;
		assign dy = cx_s[s] >>> s;
		assign ts = $signed(ZW'(qte_pkg::ATAN_TAB[s]));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cv_s[s+1] <= 1'b0;
			end else if (en) begin
				cv_s[s+1] <= cv_s[s];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (!cy_s[s][CW-1]) begin
					cx_s[s+1] <= cx_s[s] + dx;
					cy_s[s+1] <= cy_s[s] - dy;
					cz_s[s+1] <= cz_s[s] + ts;
				end else begin
					cx_s[s+1] <= cx_s[s] - dx;
					cy_s[s+1] <= cy_s[s] + dy;
					cz_s[s+1] <= cz_s[s] - ts;
				end
				cq_s[s+1] <= cq_s[s];
			end
		end
	end

	// stage 4 (after the chain): clamp to the first quadrant, then unfold
	always_comb begin
		zc = cz_s[N];
		if (zc[ZW-1]) begin
			zc = '0;
		end else if (zc > $signed(ZW'(qte_pkg::HALF_PI_Q28))) begin
			zc = $signed(ZW'(qte_pkg::HALF_PI_Q28));
		end
		mag = cq_s[N].xneg ? (qte_pkg::PI_Q28 - zc[MAG_W-1:0]) : zc[MAG_W-1:0];
		if (cq_s[N].zero) mag = '0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s4 <= mag;
			neg_s4 <= cq_s[N].yneg;
		end
	end

	// stage 5: degree conversion product
	always_ff @(posedge clk) begin
		if (en) begin
			prod_s5 <= DPW'(mag_s4 * qte_pkg::DEG_MULT);
			mag_s5  <= mag_s4;
			neg_s5  <= neg_s4;
		end
	end

	// stage 6: round half up, restore sign
	always_comb begin
		dsum = {1'b0, prod_s5} + ((DPW+1)'(1) << (qte_pkg::DEG_SH - 1));
		rsum = {1'b0, mag_s5} + ((MAG_W+1)'(1) << (qte_pkg::RAD_SH - 1));
		r = deg ? ANG_W'(dsum >> qte_pkg::DEG_SH) : ANG_W'(rsum >> qte_pkg::RAD_SH);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			angle_s6 <= neg_s5 ? (ANG_W'(0) - r) : r;
		end
	end

	assign out_valid = v_s6;
	assign angle     = angle_s6;
endmodule
`default_nettype wire

// File: rtl/core/quaternion_to_euler_angles_top.sv
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles_top: streaming quaternion to yaw, pitch, roll
// Z-Y-X Euler angles from one Q1.14 quaternion per word, fully pipelined.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one quaternion per word: real, i, j, k, 16 bits each,
//   real in the lowest bits. m_axis returns yaw, pitch, roll (15 bits each,
//   signed) in tdata and the zero-norm flag in tuser.
//   cfg_valid/cfg_data writes angle_in_degrees (1 = degrees x 64,
//   0 = radians x 4096); cfg_ready is always high. Write it only while no
//   word is in flight.
//   The pipeline has four front stages (products, sums, arcsine clamp,
//   radicand multiply), sixteen square-root stages at two root bits each,
//   then 22 arctangent stages (three setup, sixteen CORDIC rotations, three
//   quadrant and scaling stages). Yaw and roll operands wait in a register
//   delay line while the pitch root is formed.
//   Throughput is one word per cycle unless stalled. The pipeline advances
//   as one unit whenever the output register is empty or taken; a stalled
//   receiver holds the output word and freezes every stage, bubbles
//   included, and drops s_axis_tready, with nothing lost or repeated.
//   Reset clears all valid bits and sets the unit to degrees.
// ----------------------------------------------------------------------------
`default_nettype none
module quaternion_to_euler_angles_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // quat_real, quat_i, quat_j, quat_k
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [47:0] m_axis_tdata,   // yaw_angle, pitch_angle, roll_angle, 3 zero bits
	output logic        m_axis_tuser,   // zero_norm_flag
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic        cfg_data        // angle_in_degrees
);
	localparam int OP_W   = qte_pkg::OP_W;
	localparam int ROOT_W = qte_pkg::ROOT_W;
	localparam int SQN    = qte_pkg::SQ_STAGES;
	localparam int ALAT   = qte_pkg::ATAN_LAT;
	localparam int ANG_W  = qte_pkg::ANG_W;
	localparam int FW     = qte_pkg::FIELD_W;

	logic deg_q;
	logic en;
	logic fr_v, sq_v;
	qte_pkg::opnd_t fr_op, op_al;
	logic [qte_pkg::RAD_W-1:0] fr_rad;
	logic [ROOT_W-1:0] sq_root;
	qte_pkg::opnd_t op_dly [SQN];
	logic zf_dly [ALAT];
	logic signed [OP_W-1:0] pit_y, pit_x;
	logic yaw_v, pit_v, roll_v;
	logic [ANG_W-1:0] yaw, pitch, roll;

	// single global advance: move whenever the output slot frees up
	assign en            = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = en;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deg_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			deg_q <= cfg_data;
		end
	end

	qte_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (s_axis_tvalid),
		.quat_real (s_axis_tdata[FW-1:0]),
		.quat_i    (s_axis_tdata[2*FW-1:FW]),
		.quat_j    (s_axis_tdata[3*FW-1:2*FW]),
		.quat_k    (s_axis_tdata[4*FW-1:3*FW]),
		.out_valid (fr_v),
		.out_op    (fr_op),
		.out_rad   (fr_rad)
	);

	qte_isqrt u_isqrt (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (fr_v),
		.rad       (fr_rad),
		.out_valid (sq_v),
		.root      (sq_root)
	);

	// hold the other operands while the root is formed
	always_ff @(posedge clk) begin
		if (en) begin
			op_dly[0] <= fr_op;
			for (int d = 1; d < SQN; d++) op_dly[d] <= op_dly[d-1];
		end
	end

	assign op_al = op_dly[SQN-1];

	// pitch = atan2(+-a, sqrt(n^2 - a^2)); a zero norm gives a = root = 0
	assign pit_y = op_al.pit_neg ? -$signed(OP_W'(op_al.pit_a)) : $signed(OP_W'(op_al.pit_a));
	assign pit_x = $signed(OP_W'(sq_root));

	// flag rides alongside the arctangent units
	always_ff @(posedge clk) begin
		if (en) begin
			zf_dly[0] <= op_al.zero;
			for (int d = 1; d < ALAT; d++) zf_dly[d] <= zf_dly[d-1];
		end
	end

	qte_atan2 u_yaw (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_v),
		.y_in      (op_al.yaw_y),
		.x_in      (op_al.yaw_x),
		.deg       (deg_q),
		.out_valid (yaw_v),
		.angle     (yaw)
	);

	qte_atan2 u_pitch (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_v),
		.y_in      (pit_y),
		.x_in      (pit_x),
		.deg       (deg_q),
		.out_valid (pit_v),
		.angle     (pitch)
	);

	qte_atan2 u_roll (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (sq_v),
		.y_in      (op_al.roll_y),
		.x_in      (op_al.roll_x),
		.deg       (deg_q),
		.out_valid (roll_v),
		.angle     (roll)
	);

	assign m_axis_tvalid = yaw_v && pit_v && roll_v;
	assign m_axis_tdata  = {3'b000, roll, pitch, yaw};
	assign m_axis_tuser  = zf_dly[ALAT-1];

	// the three angle lanes share one valid pattern
	a_lanes: assert property (@(posedge clk) disable iff (!arst_n)
		(yaw_v == pit_v) && (pit_v == roll_v))
		else $error("angle lanes out of step");

	// a zero quaternion comes out as all-zero angles
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> (yaw == '0) && (pitch == '0) && (roll == '0))
		else $error("nonzero angle with zero norm");

	// pitch and yaw stay within ANG_MAX, plus or minus pi in radians x 4096
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> ($signed(pitch) <= $signed(ANG_W'(qte_pkg::ANG_MAX)))
			&& ($signed(pitch) >= -$signed(ANG_W'(qte_pkg::ANG_MAX)))
			&& ($signed(yaw) <= $signed(ANG_W'(qte_pkg::ANG_MAX)))
			&& ($signed(yaw) >= -$signed(ANG_W'(qte_pkg::ANG_MAX))))
		else $error("angle out of range");

	// a frozen pipeline keeps its output word
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(yaw) && $stable(pitch) && $stable(roll))
		else $error("output changed during stall");
endmodule
`default_nettype wire

// File: bench/qte_checker.sv
// ----------------------------------------------------------------------------
// qte_checker: angle predictor and scoreboard for the quaternion converter
// Watches the input, output and configuration channels, computes yaw, pitch,
// roll and the zero-norm flag for each accepted word and compares results.
// ----------------------------------------------------------------------------
module qte_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [47:0] m_axis_tdata,
	input  logic        m_axis_tuser,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic        cfg_data,
	output int          fail_count,
	output int          pending_count
);
	localparam longint HALF_PI = 421657428;
	localparam longint PI_VAL  = 843314857;
	localparam longint ATAN_Q28 [24] = '{
		210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
		4193963, 2097109, 1048571, 524287, 262144, 131072,
		65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32
	};

	typedef struct {
		logic [14:0] yaw;
		logic [14:0] pitch;
		logic [14:0] roll;
		logic        zero;
	} angles_t;

	angles_t expected_angles [$];
	logic    unit_deg;

	function automatic longint comp_value(input logic [15:0] v);
		logic [15:0] sh;
		sh = v << (16 - qte_pkg::EFF_W);
		return longint'($signed(sh) >>> (16 - qte_pkg::EFF_W));
	endfunction

	function automatic longint floor_shift(input longint v, input int s);
		return v >>> s;
	endfunction

	function automatic longint int_sqrt(input longint unsigned v);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v) b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return longint'(r);
	endfunction

	// vectoring CORDIC, result in 2^-28 rad
	function automatic longint cordic_atan2(input longint yin, input longint xin);
		longint unsigned ax, ay, m;
		longint x, y, z, dx, dy;
		ax = xin < 0 ? -xin : xin;
		ay = yin < 0 ? -yin : yin;
		m = ax > ay ? ax : ay;
		z = 0;
		if (m == 0) return 0;
		while (m < (64'd1 << 30)) begin
			m <<= 1; ax <<= 1; ay <<= 1;
		end
		while (m >= (64'd1 << 31)) begin
			m >>= 1; ax >>= 1; ay >>= 1;
		end
		x = ax;
		y = ay;
		for (int s = 0; s < qte_pkg::CORDIC_STAGES && s < 24; s++) begin
			dx = floor_shift(y, s);
			dy = floor_shift(x, s);
			if (y >= 0) begin
				x += dx; y -= dy; z += ATAN_Q28[s];
			end else begin
				x -= dx; y += dy; z -= ATAN_Q28[s];
			end
		end
		if (z < 0) z = 0;
		if (z > HALF_PI) z = HALF_PI;
		if (xin < 0) z = PI_VAL - z;
		if (yin < 0) z = -z;
		return z;
	endfunction

	function automatic logic [14:0] to_unit(input longint z, input logic deg);
		longint unsigned mag, r;
		mag = z < 0 ? -z : z;
		if (deg) r = (mag * 64'd240315917 + (64'd1 << 43)) >> 44;
		else r = (mag + (64'd1 << 15)) >> 16;
		if (z < 0) r = -r;
		return r[14:0];
	endfunction

	function automatic angles_t predict_angles(input logic [63:0] w, input logic deg);
		longint r, i, j, k, ii, jj, kk, rr, t, p;
		longint unsigned n, a, c;
		angles_t o;
		r = comp_value(w[15:0]);
		i = comp_value(w[31:16]);
		j = comp_value(w[47:32]);
		k = comp_value(w[63:48]);
		rr = r * r; ii = i * i; jj = j * j; kk = k * k;
		n = ii + jj + kk + rr;
		t = -2 * (i * k - j * r);
		p = 0;
		o.zero = (n == 0);
		if (n != 0) begin
			a = t < 0 ? -t : t;
			if (a > n) a = n;
			if (n >> 32) begin
				n >>= 1;
				a >>= 1;
			end
			c = int_sqrt((n - a) * (n + a));
			p = cordic_atan2(longint'(a), longint'(c));
			if (t < 0) p = -p;
		end
		o.yaw = to_unit(cordic_atan2(2 * (i * j + k * r), ii - jj - kk + rr), deg);
		o.pitch = to_unit(p, deg);
		o.roll = to_unit(cordic_atan2(2 * (j * k + i * r), -ii - jj + kk + rr), deg);
		return o;
	endfunction

	assign pending_count = expected_angles.size();

	always @(posedge clk or negedge arst_n) begin
		angles_t e;
		if (!arst_n) begin
			unit_deg <= 1'b1;
			fail_count <= 0;
			expected_angles.delete();
		end else begin
			if (cfg_valid && cfg_ready) unit_deg <= cfg_data;
			if (s_axis_tvalid && s_axis_tready)
				expected_angles.push_back(predict_angles(s_axis_tdata, unit_deg));
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_angles.size() == 0) begin
					if (fail_count < 10) $display("unexpected result word %h", m_axis_tdata);
					fail_count <= fail_count + 1;
				end else begin
					e = expected_angles.pop_front();
					if (m_axis_tdata[14:0] !== e.yaw || m_axis_tdata[29:15] !== e.pitch ||
					    m_axis_tdata[44:30] !== e.roll || m_axis_tdata[47:45] !== 3'b0 ||
					    m_axis_tuser !== e.zero) begin
						if (fail_count < 10)
							$display("mismatch: exp y=%h p=%h r=%h z=%b got y=%h p=%h r=%h z=%b",
								e.yaw, e.pitch, e.roll, e.zero, m_axis_tdata[14:0],
								m_axis_tdata[29:15], m_axis_tdata[44:30], m_axis_tuser);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

// File: bench/tb_quaternion_to_euler_angles_top.sv
// ----------------------------------------------------------------------------
// tb_quaternion_to_euler_angles_top: stream test of the quaternion converter
// Drives directed corner quaternions and random words in both angle units
// with random gaps and back-pressure; the checker scores every result.
// ----------------------------------------------------------------------------
module tb_quaternion_to_euler_angles_top;
	localparam int LATENCY = 42;
	localparam int CYCLE_LIMIT = 600000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [47:0] m_axis_tdata;
	logic        m_axis_tuser;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic        cfg_data = 1'b0;
	int          fail_count;
	int          pending_count;
	int          cycle_count = 0;

	always #10 clk = ~clk;

	quaternion_to_euler_angles_top dut (.*);

	qte_checker checker_u (.*);

	// mostly short gaps, now and then a long one
	function automatic int gap_len();
		int p;
		p = $urandom_range(0, 99);
		if (p < 50) return 0;
		if (p < 90) return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	// receiver back-pressure, with some long stretches of always-ready
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
		if (cycle_count % 2000 < 300) m_axis_tready <= 1'b1;
		else m_axis_tready <= ($urandom_range(0, 99) < 70);
	end

	// hold one word until it is taken, after an optional gap
	task automatic send_word(input logic [63:0] w, input bit gaps);
		int g;
		g = gaps ? gap_len() : 0;
		if (g > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= w;
		do @(posedge clk); while (!s_axis_tready);
	endtask

	// stop sending and wait until every expected result has come
	task automatic stop_and_drain();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (pending_count != 0) @(posedge clk);
	endtask

	// drain the pipeline, then write the angle unit
	task automatic set_unit(input logic deg);
		stop_and_drain();
		repeat (LATENCY + 4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= deg;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [63:0] pack_quat(input logic [15:0] r, input logic [15:0] i,
	                                          input logic [15:0] j, input logic [15:0] k);
		return {k, j, i, r};
	endfunction

	// random quaternion: components within +-0.5, full range, or sparse with extremes
	function automatic logic [63:0] rand_quat();
		logic [15:0] c [4];
		int kind;
		kind = $urandom_range(0, 9);
		for (int n = 0; n < 4; n++) begin
			if (kind < 4) c[n] = 16'($signed($urandom_range(0, 16384)) - 8192);
			else if (kind < 8) c[n] = 16'($urandom);
			else case ($urandom_range(0, 3))
				0: c[n] = 16'h0000;
				1: c[n] = 16'h8000;
				2: c[n] = 16'h7fff;
				default: c[n] = 16'($urandom);
			endcase
		end
		return pack_quat(c[0], c[1], c[2], c[3]);
	endfunction

	task automatic directed_set();
		send_word(pack_quat(16'h0000, 16'h0000, 16'h0000, 16'h0000), 1'b0); // zero norm
		send_word(pack_quat(16'h4000, 16'h0000, 16'h0000, 16'h0000), 1'b0); // identity
		send_word(pack_quat(16'h8000, 16'h8000, 16'h8000, 16'h8000), 1'b0); // largest norm
		send_word(pack_quat(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff), 1'b0);
		send_word(pack_quat(16'h8000, 16'h7fff, 16'h8000, 16'h7fff), 1'b0);
		send_word(pack_quat(16'h0000, 16'h4000, 16'h0000, 16'h0000), 1'b0); // x < 0, y = 0
		send_word(pack_quat(16'h0000, 16'h0000, 16'h4000, 16'h0000), 1'b0);
		send_word(pack_quat(16'h0000, 16'h0000, 16'h0000, 16'h4000), 1'b0);
		send_word(pack_quat(16'h2d41, 16'h0000, 16'h2d41, 16'h0000), 1'b0); // pitch +90
		send_word(pack_quat(16'h2d41, 16'h0000, 16'hd2bf, 16'h0000), 1'b0); // pitch -90
		send_word(pack_quat(16'h4000, 16'h0000, 16'h4000, 16'h0000), 1'b0); // asin saturates
		send_word(pack_quat(16'h0001, 16'h0000, 16'h0001, 16'h0000), 1'b0);
		send_word(pack_quat(16'hffff, 16'hffff, 16'h0001, 16'h0001), 1'b0);
		send_word(pack_quat(16'h5555, 16'haaaa, 16'h5555, 16'haaaa), 1'b0);
		send_word(pack_quat(16'h0000, 16'h8000, 16'h0000, 16'h0000), 1'b0);
	endtask

	initial begin
		int units [6] = '{1, 0, 1, 0, 1, 0};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		directed_set();                      // reset unit: degrees
		for (int ph = 0; ph < 6; ph++) begin
			set_unit(units[ph][0]);
			if (ph == 1 || ph == 0) directed_set();
			for (int n = 0; n < 230; n++) begin
				send_word(rand_quat(), ph != 2);
				// pause until the pipeline has fully drained
				if (n == 100) stop_and_drain();
			end
		end
		stop_and_drain();
		repeat (LATENCY + 10) @(posedge clk);
		if (fail_count == 0) $display("TEST PASSED");
		else $display("TEST FAILED");
		$finish;
	end
endmodule
